FILE: rtl/tspcr_pkg.sv
// ----------------------------------------------------------------------------
// tspcr_pkg
// Shared widths and types of the transport stream PCR bitrate estimator:
// the bit-serial divider shape and its result bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tspcr_pkg;

    // divider shape: wide dividend, divisor below 2^26, 28 quotient bits
    localparam int DIV_N_W = 60;
    localparam int DIV_D_W = 26;
    localparam int DIV_Q_W = 28;

    // status and result of the divider, seen by the sequencer
    typedef struct packed {
        logic               busy;
        logic               done;
        logic               ovf;
        logic [DIV_Q_W-1:0] quot;
    } div_res_t;

endpackage

`default_nettype wire

FILE: rtl/tspcr_div.sv
// ----------------------------------------------------------------------------
// tspcr_div
// Restoring divider, one quotient bit per cycle. A quotient that would not
// fit in DIV_Q_W bits is flagged as overflow right after start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tspcr_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [tspcr_pkg::DIV_N_W-1:0] dividend,
    input  wire logic [tspcr_pkg::DIV_D_W-1:0] divisor,
    output tspcr_pkg::div_res_t                res
);
    import tspcr_pkg::*;

    localparam int CNT_W = $clog2(DIV_Q_W);
    localparam int HI_W  = DIV_N_W - DIV_Q_W;

    logic               busy_reg;
    logic               done_reg;
    logic               ovf_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_D_W-1:0] den_reg;
    logic [DIV_Q_W-1:0] quo_reg;

    logic [HI_W-1:0]    top_bits;
    logic               start_ovf;
    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W:0]   trial_diff;
    logic               trial_ge;

    // overflow when the upper dividend bits already reach the divisor
    assign top_bits  = dividend[DIV_N_W-1:DIV_Q_W];
    assign start_ovf = top_bits >= HI_W'(divisor);

    // one restoring step: shift in the next dividend bit, try to subtract
    assign trial      = {rem_reg, quo_reg[DIV_Q_W-1]};
    assign trial_diff = trial - {1'b0, den_reg};
    assign trial_ge   = trial >= {1'b0, den_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                ovf_reg <= start_ovf;
                if (start_ovf)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CNT_W'(DIV_Q_W - 1);
                end
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    // datapath: remainder and a shift register that trades dividend bits
    // for quotient bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= divisor;
            rem_reg <= top_bits[DIV_D_W-1:0];
            quo_reg <= dividend[DIV_Q_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= trial_ge ? trial_diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            quo_reg <= {quo_reg[DIV_Q_W-2:0], trial_ge};
        end
    end

    assign res.busy = busy_reg;
    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.quot = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/ts_pcr_bitrate_estimator_unit.sv
// ----------------------------------------------------------------------------
// ts_pcr_bitrate_estimator_unit
// Per transport packet header: byte counting, PCR extraction, PCR delta,
// bitrate estimate and paced rate update with headroom, hold and smoothing.
// ----------------------------------------------------------------------------
//
//  channel   dir  beat contents (low bit first)
//  --------  ---  ---------------------------------------------------------
//  s_axis    in   tdata: sync_byte, header_byte3, adaptation_length,
//                 adaptation_flags, pcr_bytes (80 bits)
//  m_axis    out  tdata: paced_rate, zero pad (32 bits);
//                 tuser: pcr_found, estimate_used
//  cfg       in   cfg_we, cfg_addr (register index), cfg_wdata
//
//  A packet without PCR goes straight to the output register. A packet that
//  runs the estimate makes up to five passes of the shared bit-serial
//  divider (estimate, headroom, configured ceiling, rise limit, average)
//  plus sequencing.
//  One packet is worked on at a time; the next beat is taken once the result
//  sits in the output register, which holds it while m_axis_tready is low.
//  Reset clears the packet state and sets the headroom to 100; the paced rate starts at zero (unknown).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ts_pcr_bitrate_estimator_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // sync_byte, header_byte3, adaptation_length, adaptation_flags, pcr_bytes
    input  wire logic [79:0] s_axis_tdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // paced_rate, zero pad
    output logic [31:0]      m_axis_tdata,
    // pcr_found, estimate_used
    output logic [1:0]       m_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [27:0] cfg_wdata
);
    import tspcr_pkg::*;

    localparam int RATE_W  = 28;
    localparam int PCR_W   = 42;
    localparam int DELTA_W = 44;
    localparam int HR_W    = 10;
    localparam int PROD_W  = RATE_W + HR_W;
    localparam int EST_P_W = DIV_N_W - 3;

    localparam logic [RATE_W-1:0]  RATE_MIN    = 28'd512000;
    localparam logic [RATE_W-1:0]  RATE_MAX    = 28'd200000000;
    localparam logic [31:0]        PKT_BYTES   = 32'd188;
    localparam logic [31:0]        BYTES_TOP   = 32'hFFFF_FFFF - 32'd188;
    localparam logic [24:0]        PCR_HZ      = 25'd27000000;
    localparam logic [DELTA_W-1:0] PCR_WRAP    = 44'd2576980377600;
    localparam logic [DELTA_W-1:0] DELTA_LO    = 44'd27000;
    localparam logic [DELTA_W-1:0] DELTA_HI    = 44'd54000000;
    localparam logic [7:0]         SYNC_VALUE  = 8'h47;
    localparam logic [7:0]         ALEN_MIN    = 8'd7;
    localparam logic [7:0]         ALEN_MAX    = 8'd183;
    localparam logic [HR_W-1:0]    HR_DEFAULT  = 10'd100;
    localparam logic [8:0]         PCR_MUL     = 9'd300;
    localparam logic [6:0]         RISE_PCT    = 7'd125;
    localparam logic [DIV_D_W-1:0] DIV_PERCENT = 26'd100;
    localparam logic [DIV_D_W-1:0] DIV_TENTHS  = 26'd10;

    // register indexes of the configuration port
    typedef enum logic [1:0] {
        REG_HEADROOM = 2'd0,
        REG_CFG_RATE = 2'd1,
        REG_HOLD     = 2'd2,
        REG_INIT     = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PCR,
        S_DELTA,
        S_WIN,
        S_EST_MUL,
        S_EST_DIV,
        S_HR_MUL,
        S_HR_DIV,
        S_CFG_MUL,
        S_CFG_DIV,
        S_RISE,
        S_LIM_DIV,
        S_AVG,
        S_AVG_DIV,
        S_EMIT
    } state_t;

    function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] r);
        if (r < RATE_MIN)
            return RATE_MIN;
        else if (r > RATE_MAX)
            return RATE_MAX;
        else
            return r;
    endfunction

    // configuration
    logic [HR_W-1:0]     headroom_reg;
    logic [RATE_W-1:0]   cfg_rate_reg;
    logic                hold_reg;

    // packet state
    state_t              state_reg;
    logic [PCR_W-1:0]    prev_pcr_reg;
    logic                have_pcr_reg;
    logic [31:0]         bytes_reg;
    logic [RATE_W-1:0]   cur_reg;
    logic [47:0]         raw_reg;
    logic [PCR_W-1:0]    pcr_reg;
    logic [DELTA_W-1:0]  delta_reg;
    logic [RATE_W-1:0]   est_reg;
    logic                found_reg;
    logic                used_reg;

    // divider handoff
    logic                div_start_reg;
    logic [DIV_N_W-1:0]  div_n_reg;
    logic [DIV_D_W-1:0]  div_d_reg;
    div_res_t            div_res;

    // output register
    logic                m_valid_reg;
    logic [RATE_W-1:0]   m_rate_reg;
    logic                m_found_reg;
    logic                m_used_reg;

    logic                accept;
    logic                pcr_ok;
    logic [31:0]         bytes_next;
    logic [HR_W-1:0]     hr_eff;
    logic [RATE_W-1:0]   cfg_eff;
    logic [RATE_W-1:0]   quot_rate;
    logic [RATE_W-1:0]   quot_clamped;
    logic [RATE_W:0]     cur_plus1;
    logic [RATE_W:0]     rise_lim;
    logic                out_free;

    tspcr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_n_reg),
        .divisor  (div_d_reg),
        .res      (div_res)
    );

    // header checks on the incoming beat
    assign accept = s_axis_tvalid && s_axis_tready;
    assign pcr_ok = (s_axis_tdata[7:0] == SYNC_VALUE) && s_axis_tdata[13] &&
                    (s_axis_tdata[23:16] >= ALEN_MIN) &&
                    (s_axis_tdata[23:16] <= ALEN_MAX) && s_axis_tdata[28];

    // saturating byte count
    assign bytes_next = (bytes_reg > BYTES_TOP) ? 32'hFFFF_FFFF : bytes_reg + PKT_BYTES;

    // effective headroom and configured rate
    assign hr_eff  = (headroom_reg == '0) ? HR_DEFAULT : headroom_reg;
    assign cfg_eff = (cfg_rate_reg == '0) ? '0 : clamp_rate(cfg_rate_reg);

    // divider result as a rate: overflow and range clamp
    assign quot_rate    = div_res.quot[RATE_W-1:0];
    assign quot_clamped = div_res.ovf ? RATE_MAX : clamp_rate(quot_rate);

    // rise limit: at least one above the current rate
    assign cur_plus1 = {1'b0, cur_reg} + {{RATE_W{1'b0}}, 1'b1};
    assign rise_lim  = ({1'b0, quot_rate} < cur_plus1) ? cur_plus1 : {1'b0, quot_rate};

    assign out_free = !m_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            headroom_reg <= HR_DEFAULT;
            cfg_rate_reg <= '0;
            hold_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_HEADROOM: headroom_reg <= cfg_wdata[HR_W-1:0];
                REG_CFG_RATE: cfg_rate_reg <= cfg_wdata;
                REG_HOLD:     hold_reg     <= cfg_wdata[0];
                default:      ;
            endcase
        end
    end

    // packet sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_pcr_reg  <= '0;
            have_pcr_reg  <= 1'b0;
            bytes_reg     <= '0;
            cur_reg       <= '0;
            raw_reg       <= '0;
            pcr_reg       <= '0;
            delta_reg     <= '0;
            est_reg       <= '0;
            found_reg     <= 1'b0;
            used_reg      <= 1'b0;
            div_start_reg <= 1'b0;
            div_n_reg     <= '0;
            div_d_reg     <= '0;
            m_valid_reg   <= 1'b0;
            m_rate_reg    <= '0;
            m_found_reg   <= 1'b0;
            m_used_reg    <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;

            // output beat taken, unless a new result replaces it
            if (m_valid_reg && m_axis_tready && (state_reg != S_EMIT))
            begin
                m_valid_reg <= 1'b0;
            end

            // initial rate loads the paced rate at once
            if (cfg_we && (cfg_addr == REG_INIT) && (cfg_wdata != '0))
            begin
                cur_reg <= clamp_rate(cfg_wdata);
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        bytes_reg <= bytes_next;
                        raw_reg   <= s_axis_tdata[79:32];
                        found_reg <= pcr_ok;
                        used_reg  <= 1'b0;
                        state_reg <= pcr_ok ? S_PCR : S_EMIT;
                    end
                end

                // pcr = base * 300 + extension
                S_PCR:
                begin
                    pcr_reg   <= PCR_W'(raw_reg[47:15]) * PCR_W'(PCR_MUL) +
                                 PCR_W'(raw_reg[8:0]);
                    state_reg <= S_DELTA;
                end

                // wrapped delta, then the new reference
                S_DELTA:
                begin
                    if (pcr_reg >= prev_pcr_reg)
                        delta_reg <= DELTA_W'(pcr_reg) - DELTA_W'(prev_pcr_reg);
                    else
                        delta_reg <= PCR_WRAP + DELTA_W'(pcr_reg) - DELTA_W'(prev_pcr_reg);
                    prev_pcr_reg <= pcr_reg;
                    have_pcr_reg <= 1'b1;
                    if (have_pcr_reg)
                    begin
                        state_reg <= S_WIN;
                    end
                    else
                    begin
                        bytes_reg <= '0;
                        state_reg <= S_EMIT;
                    end
                end

                // 1 ms .. 2 s window; a negative wrap fails on the sign bit
                S_WIN:
                begin
                    if (!delta_reg[DELTA_W-1] && (delta_reg > DELTA_LO) &&
                        (delta_reg < DELTA_HI))
                    begin
                        state_reg <= S_EST_MUL;
                    end
                    else
                    begin
                        bytes_reg <= '0;
                        state_reg <= S_EMIT;
                    end
                end

                // bits * 27 MHz over the delta
                S_EST_MUL:
                begin
                    div_n_reg     <= {EST_P_W'(bytes_reg) * EST_P_W'(PCR_HZ), 3'b000};
                    div_d_reg     <= delta_reg[DIV_D_W-1:0];
                    div_start_reg <= 1'b1;
                    bytes_reg     <= '0;
                    state_reg     <= S_EST_DIV;
                end

                S_EST_DIV:
                begin
                    if (div_res.done)
                    begin
                        est_reg <= quot_rate;
                        if (!div_res.ovf && (quot_rate >= RATE_MIN) &&
                            (quot_rate <= RATE_MAX))
                            state_reg <= S_HR_MUL;
                        else
                            state_reg <= S_EMIT;
                    end
                end

                // estimate scaled by headroom percent
                S_HR_MUL:
                begin
                    div_n_reg     <= DIV_N_W'(PROD_W'(est_reg) * PROD_W'(hr_eff));
                    div_d_reg     <= DIV_PERCENT;
                    div_start_reg <= 1'b1;
                    state_reg     <= S_HR_DIV;
                end

                S_HR_DIV:
                begin
                    if (div_res.done)
                    begin
                        est_reg  <= quot_clamped;
                        used_reg <= 1'b1;
                        if (hold_reg && (cfg_eff != '0))
                            state_reg <= S_CFG_MUL;
                        else
                            state_reg <= S_RISE;
                    end
                end

                // ceiling of the configured rate with headroom
                S_CFG_MUL:
                begin
                    div_n_reg     <= DIV_N_W'(PROD_W'(cfg_eff) * PROD_W'(hr_eff));
                    div_d_reg     <= DIV_PERCENT;
                    div_start_reg <= 1'b1;
                    state_reg     <= S_CFG_DIV;
                end

                S_CFG_DIV:
                begin
                    if (div_res.done)
                    begin
                        if (est_reg <= quot_clamped)
                        begin
                            cur_reg   <= cfg_eff;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_RISE;
                        end
                    end
                end

                // first estimate is taken as is, a rise is limited to 125%
                S_RISE:
                begin
                    if (cur_reg == '0)
                    begin
                        cur_reg   <= est_reg;
                        state_reg <= S_EMIT;
                    end
                    else if (est_reg > cur_reg)
                    begin
                        div_n_reg     <= DIV_N_W'(PROD_W'(cur_reg) * PROD_W'(RISE_PCT));
                        div_d_reg     <= DIV_PERCENT;
                        div_start_reg <= 1'b1;
                        state_reg     <= S_LIM_DIV;
                    end
                    else
                    begin
                        state_reg <= S_AVG;
                    end
                end

                S_LIM_DIV:
                begin
                    if (div_res.done)
                    begin
                        if ({1'b0, est_reg} > rise_lim)
                            est_reg <= rise_lim[RATE_W-1:0];
                        state_reg <= S_AVG;
                    end
                end

                // 7:3 weighted average
                S_AVG:
                begin
                    div_n_reg     <= DIV_N_W'({cur_reg, 3'b000}) - DIV_N_W'(cur_reg) +
                                     DIV_N_W'({est_reg, 1'b0}) + DIV_N_W'(est_reg);
                    div_d_reg     <= DIV_TENTHS;
                    div_start_reg <= 1'b1;
                    state_reg     <= S_AVG_DIV;
                end

                S_AVG_DIV:
                begin
                    if (div_res.done)
                    begin
                        cur_reg   <= quot_rate;
                        state_reg <= S_EMIT;
                    end
                end

                // result into the output register once it is free
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_rate_reg  <= cur_reg;
                        m_found_reg <= found_reg;
                        m_used_reg  <= used_reg;
                        state_reg   <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0000, m_rate_reg};
    assign m_axis_tuser  = {m_used_reg, m_found_reg};

    // an estimate is only ever used on a packet that carried a PCR
    a_used_needs_pcr: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] || !m_axis_tuser[1]))
        else $error("estimate_used without pcr_found");

    // the paced rate is unknown or inside the rate limits
    a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_reg == '0) || ((cur_reg >= RATE_MIN) && (cur_reg <= RATE_MAX)))
        else $error("paced rate out of limits");

    // the divider is idle whenever a new packet may enter
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (!div_res.busy && !div_start_reg))
        else $error("divider busy while accepting");

    // one packet at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_axis_tready)
        else $error("input taken while a packet is in work");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the transport stream PCR bitrate estimator. Packet
// headers go in on the input stream; a predictor follows byte count, PCR
// reference and paced rate, and every output beat is compared with the
// oldest predicted one. Register settings change between traffic phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam bit [63:0] PCR_WRAP   = 64'd2576980377600;
    localparam bit [63:0] RATE_MIN   = 64'd512000;
    localparam bit [63:0] RATE_MAX   = 64'd200000000;
    localparam bit [63:0] BITS_TICKS = 64'd216000000;   // 8 bits * 27 MHz
    localparam bit [63:0] PKT_BYTES  = 64'd188;

    typedef enum bit [1:0]
    {
        REG_HEADROOM  = 2'd0,
        REG_CFG_RATE  = 2'd1,
        REG_HOLD      = 2'd2,
        REG_INIT_RATE = 2'd3
    } cfg_reg_e;

    // header fields, sync byte in the low bits as on the bus
    typedef struct packed {
        bit [47:0] pcr_bytes;
        bit [7:0]  flags;
        bit [7:0]  alen;
        bit [7:0]  hb3;
        bit [7:0]  sync;
    } ts_header_t;

    typedef struct {
        bit [27:0] rate;
        bit        pcr_found;
        bit        est_used;
    } pacing_result_t;

    // predicted pacing state and the beats still owed by the block
    class paced_rate_predictor;
        bit [9:0]       headroom;
        bit [27:0]      cfg_rate;
        bit             hold;
        bit [63:0]      last_pcr;
        bit             have_pcr;
        bit [31:0]      byte_count;
        bit [63:0]      cur_rate;
        pacing_result_t awaited_rates[$];
        int             errors;
        int             checked;
        int             pcr_seen;
        int             est_applied;

        function new();
            headroom   = 10'd100;
            cfg_rate   = '0;
            hold       = 1'b0;
            last_pcr   = '0;
            have_pcr   = 1'b0;
            byte_count = '0;
            cur_rate   = '0;
        endfunction

        function bit [63:0] clamp_rate(input bit [63:0] r);
            if (r < RATE_MIN)
            begin
                return RATE_MIN;
            end
            if (r > RATE_MAX)
            begin
                return RATE_MAX;
            end
            return r;
        endfunction

        function bit [63:0] scaled(input bit [63:0] r);
            bit [63:0] pct;
            bit [63:0] c;
            pct = (headroom == 0) ? 64'd100 : 64'(headroom);
            c   = (r > RATE_MAX) ? RATE_MAX : r;
            return clamp_rate(c * pct / 64'd100);
        endfunction

        // paced rate update from one in-range estimate
        function bit apply_estimate(input bit [63:0] est);
            bit [63:0] cfg;
            bit [63:0] lim;
            if (est < RATE_MIN || est > RATE_MAX)
            begin
                return 1'b0;
            end
            est = scaled(est);
            cfg = (cfg_rate == 0) ? 64'd0 : clamp_rate(64'(cfg_rate));
            if (hold && cfg != 0 && est <= scaled(cfg))
            begin
                cur_rate = cfg;
                return 1'b1;
            end
            if (cur_rate == 0)
            begin
                cur_rate = est;
                return 1'b1;
            end
            if (est > cur_rate)
            begin
                lim = cur_rate * 64'd125 / 64'd100;
                if (lim < cur_rate + 1)
                begin
                    lim = cur_rate + 1;
                end
                if (est > lim)
                begin
                    est = lim;
                end
            end
            cur_rate = (cur_rate * 64'd7 + est * 64'd3) / 64'd10;
            return 1'b1;
        endfunction

        function void write_reg(input cfg_reg_e idx, input bit [27:0] val);
            case (idx)
                REG_HEADROOM:  headroom = val[9:0];
                REG_CFG_RATE:  cfg_rate = val;
                REG_HOLD:      hold     = val[0];
                REG_INIT_RATE:
                begin
                    if (val != 0)
                    begin
                        cur_rate = clamp_rate(64'(val));
                    end
                end
                default: ;
            endcase
        endfunction

        // one accepted header beat, one predicted output beat
        function void take_packet(input ts_header_t h);
            bit [63:0]      pcr;
            bit [63:0]      delta;
            bit [63:0]      est;
            pacing_result_t r;
            r.pcr_found = 1'b0;
            r.est_used  = 1'b0;
            if (byte_count > 32'hFFFFFFFF - 32'd188)
            begin
                byte_count = 32'hFFFFFFFF;
            end
            else
            begin
                byte_count = byte_count + 32'd188;
            end
            if (h.sync == 8'h47 && h.hb3[5] && h.alen >= 8'd7 && h.alen <= 8'd183
                && h.flags[4])
            begin
                pcr = 64'(h.pcr_bytes[47:15]) * 64'd300 + 64'(h.pcr_bytes[8:0]);
                r.pcr_found = 1'b1;
                pcr_seen++;
                if (have_pcr)
                begin
                    delta = (pcr >= last_pcr) ? pcr - last_pcr : PCR_WRAP - last_pcr + pcr;
                    if (delta > 64'd27000 && delta < 64'd54000000)
                    begin
                        est = 64'(byte_count) * BITS_TICKS / delta;
                        r.est_used = apply_estimate(est);
                    end
                end
                last_pcr   = pcr;
                have_pcr   = 1'b1;
                byte_count = '0;
            end
            if (r.est_used)
            begin
                est_applied++;
            end
            r.rate = cur_rate[27:0];
            awaited_rates.insert(awaited_rates.size(), r);
        endfunction

        function void check_output(input bit [27:0] rate, input bit found,
                                   input bit used);
            pacing_result_t e;
            checked++;
            if (awaited_rates.size() == 0)
            begin
                $error("output beat with no packet pending: paced_rate %0d", rate);
                errors++;
                return;
            end
            e = awaited_rates[0];
            awaited_rates.delete(0);
            if (rate != e.rate)
            begin
                $error("paced_rate: expected %0d, got %0d", e.rate, rate);
                errors++;
            end
            if (found != e.pcr_found)
            begin
                $error("pcr_found: expected %0d, got %0d", e.pcr_found, found);
                errors++;
            end
            if (used != e.est_used)
            begin
                $error("estimate_used: expected %0d, got %0d", e.est_used, used);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    // sync_byte, header_byte3, adaptation_length, adaptation_flags, pcr_bytes
    logic [79:0] s_axis_tdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // paced_rate, zero pad
    logic [31:0] m_axis_tdata;
    // pcr_found, estimate_used
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [27:0] cfg_wdata = '0;

    paced_rate_predictor rate_pred = new();
    bit [63:0]           pcr_clock;
    bit                  quiet_stretch;
    int                  packets_sent;

    ts_pcr_bitrate_estimator_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #30_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // PCR header with the given adaptation control and length, random bits where the block does not look
    function automatic ts_header_t make_pcr(input bit [63:0] pcr_val, input bit [1:0] afc,
                                            input bit [7:0] alen);
        ts_header_t h;
        bit [63:0]  base;
        base   = pcr_val / 64'd300;
        h.sync = 8'h47;
        h.hb3  = 8'($urandom);
        h.hb3[5:4] = afc;
        h.alen  = alen;
        h.flags = 8'($urandom) | 8'h10;
        h.pcr_bytes[47:15] = base[32:0];
        h.pcr_bytes[14:9]  = 6'($urandom);
        h.pcr_bytes[8:0]   = 9'(pcr_val % 64'd300);
        return h;
    endfunction

    // packet between PCRs: payload only, adaptation without PCR, broken or noise
    function automatic ts_header_t make_filler();
        ts_header_t h;
        int         kind;
        kind = $urandom_range(0, 9);
        h = make_pcr(pcr_clock + 64'($urandom_range(0, 100000)),
                     2'($urandom_range(2, 3)), 8'($urandom_range(7, 183)));
        if (kind <= 1)
        begin
            h = {16'($urandom), $urandom, $urandom};
        end
        else if (kind <= 4)
        begin
            h.hb3[5:4] = 2'($urandom_range(0, 1));
        end
        else if (kind <= 6)
        begin
            h.flags[4] = 1'b0;
        end
        else if (kind == 7)
        begin
            h.sync = 8'($urandom);
            if (h.sync == 8'h47)
            begin
                h.sync = 8'h46;
            end
        end
        else if (kind == 8)
        begin
            h.alen = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 6))
                                                 : 8'($urandom_range(184, 255));
        end
        else
        begin
            h.hb3[5:4] = 2'($urandom_range(0, 1));
            h.flags[4] = 1'b0;
        end
        return h;
    endfunction

    // offer one header beat and wait until it is taken
    task automatic send_packet(input ts_header_t h);
        int gap;
        gap = quiet_stretch ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 63) == 0)
        begin
            quiet_stretch = !quiet_stretch;
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= h;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        rate_pred.take_packet(h);
        packets_sent++;
    endtask

    // next PCR on the running clock, delta ticks later
    task automatic send_pcr(input bit [63:0] delta, input bit [1:0] afc,
                            input bit [7:0] alen);
        pcr_clock = (pcr_clock + delta) % PCR_WRAP;
        send_packet(make_pcr(pcr_clock, afc, alen));
    endtask

    // drain the block before touching registers
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (rate_pred.awaited_rates.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // write all four registers, initial rate last
    task automatic load_settings(input bit [27:0] hr, input bit [27:0] cr,
                                 input bit [27:0] hd, input bit [27:0] ir);
        bit [27:0] vals [4];
        vals = '{hr, cr, hd, ir};
        cfg_we <= 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            cfg_addr  <= 2'(i);
            cfg_wdata <= vals[i];
            @(posedge clk);
            rate_pred.write_reg(cfg_reg_e'(i), vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // edge cases: field extremes, delta window edges, rise limit, wrap
    task automatic directed_packets();
        ts_header_t h;
        h = '0;
        send_packet(h);
        h = '1;
        send_packet(h);
        pcr_clock = '0;
        send_packet(make_pcr(pcr_clock, 2'd2, 8'd7));
        h = '0;
        h.sync = 8'h47;
        h.hb3  = 8'h10;
        send_packet(h);
        send_pcr(64'd27000, 2'd3, 8'd183);
        send_pcr(64'd27001, 2'd2, 8'd7);
        send_pcr(64'd53999999, 2'd3, 8'd100);
        send_pcr(64'd54000000, 2'd2, 8'd50);
        // one condition broken each
        h = make_pcr(pcr_clock + 64'd30000, 2'd2, 8'd20);
        h.sync = 8'h46;
        send_packet(h);
        h = make_pcr(pcr_clock + 64'd30000, 2'd0, 8'd20);
        send_packet(h);
        h = make_pcr(pcr_clock + 64'd30000, 2'd1, 8'd20);
        send_packet(h);
        h = make_pcr(pcr_clock + 64'd30000, 2'd3, 8'd6);
        send_packet(h);
        h = make_pcr(pcr_clock + 64'd30000, 2'd3, 8'd184);
        send_packet(h);
        h = make_pcr(pcr_clock + 64'd30000, 2'd2, 8'd20);
        h.flags[4] = 1'b0;
        send_packet(h);
        // large estimate after many bytes: rise is limited
        send_pcr(64'd27001, 2'd2, 8'd20);
        send_pcr(64'd60000, 2'd3, 8'd20);
        // base at maximum with extension above 299, then a delta that wraps to huge
        pcr_clock = 64'h1FFFFFFFF * 64'd300;
        h = make_pcr(pcr_clock, 2'd2, 8'd20);
        h.pcr_bytes[8:0] = 9'h1FF;
        send_packet(h);
        pcr_clock = 64'd100;
        send_packet(make_pcr(pcr_clock, 2'd2, 8'd20));
        // ordinary wrap of the PCR clock
        pcr_clock = PCR_WRAP - 64'd10000;
        send_packet(make_pcr(pcr_clock, 2'd3, 8'd20));
        send_pcr(64'd40000, 2'd3, 8'd20);
    endtask

    // runs of filler packets closed by a PCR whose delta aims at a bitrate
    task automatic random_traffic(input int count);
        int         sent_here;
        int         n_fill;
        int         mode;
        int         long_at;
        bit         long_done;
        bit [63:0]  top;
        bit [63:0]  rate_goal;
        bit [63:0]  delta;
        ts_header_t h;
        sent_here = 0;
        long_done = 1'b0;
        long_at   = $urandom_range(0, count / 2);
        while (sent_here < count)
        begin
            n_fill = $urandom_range(0, 5);
            if (!long_done && sent_here >= long_at)
            begin
                n_fill    = $urandom_range(135, 220);
                long_done = 1'b1;
            end
            repeat (n_fill) send_packet(make_filler());
            top = 64'(n_fill + 1) * 64'd1600000;
            if (top > 64'd250000000)
            begin
                top = 64'd250000000;
            end
            rate_goal = 64'($urandom_range(400000, 32'(top)));
            delta = 64'(n_fill + 1) * PKT_BYTES * BITS_TICKS / rate_goal;
            mode  = $urandom_range(0, 19);
            case (mode)
                14: delta = 64'($urandom_range(0, 27000));
                15: delta = 64'($urandom_range(54000000, 60000000));
                16: delta = 64'd27000 + 64'($urandom_range(0, 2));
                17: delta = 64'd54000000 - 64'($urandom_range(0, 2));
                18:
                begin
                    pcr_clock = PCR_WRAP - 64'($urandom_range(1, 100000));
                    delta     = '0;
                end
                default: ;
            endcase
            pcr_clock = (pcr_clock + delta) % PCR_WRAP;
            h = make_pcr(pcr_clock, 2'($urandom_range(2, 3)), 8'($urandom_range(7, 183)));
            if (mode == 19)
            begin
                h.pcr_bytes[8:0] = 9'($urandom_range(300, 511));
            end
            send_packet(h);
            sent_here += n_fill + 1;
        end
    endtask

    // output side: random stalls, a few long hold-offs
    initial
    begin
        int results;
        int stall_left;
        results    = 0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                rate_pred.check_output(m_axis_tdata[27:0], m_axis_tuser[0], m_axis_tuser[1]);
                results++;
                if (results % 400 == 100)
                begin
                    stall_left = 300;
                end
                else
                begin
                    stall_left = quiet_stretch ? 0 : $urandom_range(0, 4);
                end
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            m_axis_tready <= (stall_left == 0);
        end
    end

    // main sequence
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_packets();
        wait_idle();

        // zero headroom means 100, zero initial rate keeps the current one
        load_settings(28'd0, 28'd0, 28'd0, 28'd0);
        random_traffic(300);
        wait_idle();

        // all-ones registers: maximum headroom, rates clamped to the ceiling
        load_settings(28'h3FF, 28'hFFFFFFF, 28'h1, 28'hFFFFFFF);
        random_traffic(120);
        wait_idle();

        // minimum nonzero values, clamped up to the floor
        load_settings(28'd1, 28'd1, 28'd0, 28'd1);
        random_traffic(200);
        wait_idle();

        // hold near the configured rate, estimates around it
        load_settings(28'($urandom_range(80, 150)), 28'($urandom_range(512000, 3000000)),
                      28'd1, 28'($urandom));
        random_traffic(300);
        wait_idle();

        load_settings(28'($urandom_range(0, 1023)), 28'($urandom), 28'($urandom_range(0, 1)),
                      28'd0);
        random_traffic(200);
        wait_idle();
        repeat (200) @(posedge clk);

        $display("summary: %0d packets sent, %0d beats checked", packets_sent,
                 rate_pred.checked);
        $display("summary: %0d carried a PCR, %0d updated the paced rate",
                 rate_pred.pcr_seen, rate_pred.est_applied);
        if (rate_pred.errors == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
